[rtl/core/qsg_pkg.sv]
// Package with shared constants and the arctangent function of the quantized sine generator.
`timescale 1ns / 1ps
package qsg_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegSampleRate    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSampleBits    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegToneFrequency = 2'd2;
  localparam logic [CfgIdxW-1:0] RegAmplitude     = 2'd3;
  localparam logic [1:0] Bits8  = 2'd0;
  localparam logic [1:0] Bits16 = 2'd1;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [31:0] ByteOffset = 32'sd128;
  localparam logic [30:0] Limit8  = 31'd127;
  localparam logic [30:0] Limit16 = 31'd32767;
  localparam logic [30:0] Limit32 = 31'h7FFFFFFF;

  // Arctangent table, 2^32 per turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] r;
    begin
      case (k)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
        5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
        5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
        5'd30: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction
endpackage

[rtl/core/quantized_sine_generator.sv]
// Quantized sine generator top level: phase residue, divider, CORDIC, scaling.
// Sequence from tick to sample: fold the phase and step by the rate, divide into a turn fraction,
// fold the angle into the right half plane, rotate with CORDIC, multiply by the amplitude, then round.
// The serial units take one tick at a time; a new tick is accepted only once its sample is finished.
// A finished sample waits in the output register while the next tick is accepted.
// rst_ni clears control state and restores the register reset values asynchronously.
`timescale 1ns / 1ps
module quantized_sine_generator #(
  parameter int unsigned RATE_BITS    = 18,
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sample_value
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned RB = RATE_BITS;
  localparam int unsigned KW = $clog2(RB + 33);
  localparam int unsigned NW = RB + 32;

  typedef enum logic [3:0] {
    S_IDLE, S_FOLD, S_DIV, S_ROT, S_CORDIC, S_MUL, S_FIN, S_OUT
  } state_e;

  state_e state_q;
  logic [RB-1:0] rate_q, tone_q, phase_q, step_q;
  logic [1:0]    bits_q;
  logic [30:0]   amp_q;
  logic [RB-1:0] fs_q;
  logic [KW-1:0] cnt_q;
  logic [1:0]    pass_q;  // fold pass: 0 phase, 1 step
  logic          restart_q;
  logic [NW-1:0] num_q;   // dividend shifting out MSB first
  logic [RB:0]   rem_q;
  logic [31:0]   quo_q;
  logic [RB-1:0] pfold_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic          flip_q;
  logic [30:0]   a_q;
  logic signed [63:0] acc_q;
  logic [30:0]   mul_q;
  logic [31:0]   out_q;
  logic          oval_q;

  logic [RB-1:0] fs_c;
  logic [30:0]   lim_c;
  logic [30:0]   alim_c;
  logic [RB:0]   rsh_c;
  logic          qbit_c;
  logic [RB:0]   rnx_c;
  logic signed [33:0] dx_c, dy_c;
  logic [31:0]   at_c;
  logic signed [33:0] zt_c, zf_c;
  logic          flip_c;
  logic signed [63:0] pp_c;
  logic signed [63:0] v_c;
  logic [31:0]   clamp_c;

  assign fs_c   = (rate_q == '0) ? RB'(1) : rate_q;
  assign lim_c  = (bits_q == qsg_pkg::Bits8) ? qsg_pkg::Limit8 :
                  (bits_q == qsg_pkg::Bits16) ? qsg_pkg::Limit16 : qsg_pkg::Limit32;
  assign alim_c = (amp_q < lim_c) ? amp_q : lim_c;
  assign rsh_c  = {rem_q[RB-1:0], num_q[NW-1]};
  assign qbit_c = (rsh_c >= {1'b0, fs_q});
  assign rnx_c  = qbit_c ? (rsh_c - {1'b0, fs_q}) : rsh_c;
  assign dx_c   = y_q >>> cnt_q;
  assign dy_c   = x_q >>> cnt_q;
  assign at_c   = qsg_pkg::atan_turn(cnt_q[4:0]);
  assign pp_c   = 64'(y_q) <<< cnt_q;
  assign v_c    = acc_q >>> 30;

  // Fold the angle into the right half plane.
  assign zt_c   = $signed({{2{quo_q[31]}}, quo_q});
  assign flip_c = (zt_c > 34'sh40000000) || (zt_c < -34'sh40000000);
  assign zf_c   = (zt_c > 34'sh40000000) ? (zt_c - 34'sh80000000) :
                  (zt_c < -34'sh40000000) ? (zt_c + 34'sh80000000) : zt_c;

  // Clamp the rounded product to the amplitude.
  assign clamp_c = (v_c > $signed({33'd0, a_q})) ? {1'b0, a_q} :
                   (v_c < -$signed({33'd0, a_q})) ? -{1'b0, a_q} : v_c[31:0];

  assign s_axis_tready = (state_q == S_IDLE) || (state_q == S_OUT);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = out_q;

  // Hold registers, sequence one tick through fold, divide, CORDIC and multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rate_q <= RB'(8000); bits_q <= 2'd1; tone_q <= RB'(440); amp_q <= 31'd1000;
      phase_q <= '0; step_q <= '0; oval_q <= 1'b0; cnt_q <= '0; pass_q <= '0;
      restart_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          qsg_pkg::RegSampleRate:    rate_q <= cfg_data_i[RB-1:0];
          qsg_pkg::RegSampleBits:    bits_q <= cfg_data_i[1:0];
          qsg_pkg::RegToneFrequency: tone_q <= cfg_data_i[RB-1:0];
          qsg_pkg::RegAmplitude:     amp_q  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      // Drop the output transaction once taken, unless a new sample replaces it.
      if (m_axis_tvalid && m_axis_tready && state_q != S_FIN) oval_q <= 1'b0;
      unique case (state_q) inside
        S_IDLE, S_OUT: begin
          if (s_axis_tvalid && s_axis_tready) begin
            restart_q <= s_axis_tdata[0];
            fs_q   <= fs_c;
            pass_q <= 2'd0;
            // Reduce phase (tone on restart handled in pass 1) by the rate.
            num_q  <= s_axis_tdata[0] ? '0 : {phase_q, 32'd0};
            rem_q  <= '0;
            cnt_q  <= KW'(RB);
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          // Restoring remainder, one bit a cycle.
          if (cnt_q == KW'(1)) begin
            rem_q <= '0;
            if (pass_q == 2'd0) begin
              pass_q <= 2'd1;
              num_q <= {(restart_q ? tone_q : step_q), 32'd0};
              cnt_q <= KW'(RB);
              pfold_q <= rnx_c[RB-1:0];
            end else begin
              step_q <= rnx_c[RB-1:0];
              num_q <= {pfold_q, 32'd0};
              quo_q <= '0; cnt_q <= KW'(NW);
              state_q <= S_DIV;
            end
          end else begin
            num_q <= num_q << 1;
            rem_q <= rnx_c;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DIV: begin
          num_q <= num_q << 1;
          quo_q <= {quo_q[30:0], qbit_c};
          rem_q <= rnx_c;
          if (cnt_q == KW'(1)) state_q <= S_ROT;
          else cnt_q <= cnt_q - 1'b1;
        end
        S_ROT: begin
          z_q <= zf_c;
          flip_q <= flip_c;
          x_q <= qsg_pkg::CordicGain; y_q <= '0; cnt_q <= '0;
          a_q <= alim_c;
          acc_q <= 64'sh20000000; mul_q <= alim_c;
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!z_q[33]) begin
            x_q <= x_q - dx_c; y_q <= y_q + dy_c; z_q <= z_q - $signed({2'b0, at_c});
          end else begin
            x_q <= x_q + dx_c; y_q <= y_q - dy_c; z_q <= z_q + $signed({2'b0, at_c});
          end
          if (cnt_q == KW'(CORDIC_STEPS - 1)) begin
            state_q <= S_MUL;
            cnt_q <= '0;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_MUL: begin
          // Shift-add multiply, one amplitude bit a cycle; subtract for a flipped angle.
          if (mul_q[0]) acc_q <= flip_q ? (acc_q - pp_c) : (acc_q + pp_c);
          mul_q <= mul_q >> 1;
          if (cnt_q == KW'(30)) state_q <= S_FIN;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_FIN: begin
          if (!oval_q || m_axis_tready) begin
            out_q <= (bits_q == qsg_pkg::Bits8) ? (clamp_c + qsg_pkg::ByteOffset) : clamp_c;
            oval_q <= 1'b1;
            phase_q <= ({1'b0, pfold_q} + {1'b0, step_q} >= {1'b0, fs_q}) ?
                       RB'({1'b0, pfold_q} + {1'b0, step_q} - {1'b0, fs_q}) :
                       RB'({1'b0, pfold_q} + {1'b0, step_q});
            state_q <= S_OUT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/qsg_checker.sv]
// Port-level assertions for the quantized sine generator, bound to the top level.
`timescale 1ns / 1ps
module qsg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled sample changed");
  // A tick never yields a result on the next cycle.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");
  // No tick accepted right after another one while the first is in work.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second tick taken");
endmodule

bind quantized_sine_generator qsg_checker u_qsg_checker (.*);

[bench/tb_quantized_sine_generator.sv]
// Testbench for the quantized sine generator: random ticks checked against a local predictor.
`timescale 1ns / 1ps
module tb_quantized_sine_generator;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] sample_value
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  quantized_sine_generator DUT (.*);

  always #1 clk_i = ~clk_i;

  // Mirror of the block's registers and phase state
  logic [17:0] fs_reg, tone_reg, phase_res, phase_inc;
  logic [1:0]  width_sel;
  logic [30:0] peak_reg;

  bit          tick_queue[$];      // pending restart flags
  logic [31:0] expected_samples[$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;       // no idling on either side
  int          send_wait = 0;
  int          recv_wait = 0;

  localparam longint AtanTab[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  // Rotation-mode CORDIC, sin in Q1.30 from a 32-bit turn fraction
  function automatic longint sine_q30(input logic [31:0] turn);
    longint z, x, y, dx, dy;
    bit flip;
    z = $signed({32'b0, turn});
    if (turn[31]) z = z - (64'sd1 <<< 32);
    x = 64'sd652032874;
    y = 0;
    flip = 1'b0;
    if (z > (64'sd1 <<< 30)) begin
      z = z - (64'sd1 <<< 31);
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z = z + (64'sd1 <<< 31);
      flip = 1'b1;
    end
    for (int k = 0; k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - AtanTab[k];
      end else begin
        x = x + dx; y = y - dy; z = z + AtanTab[k];
      end
    end
    return flip ? -y : y;
  endfunction

  // Next PCM sample; advances the mirrored phase
  function automatic logic [31:0] next_sample(input bit restart);
    longint unsigned fs, p, s, turn;
    longint lim, a, v;
    fs = (fs_reg == 0) ? 1 : fs_reg;
    if (restart) begin
      phase_res = '0;
      phase_inc = 18'(tone_reg % fs);
    end
    p = phase_res % fs;
    s = phase_inc % fs;
    turn = (p << 32) / fs;
    if (width_sel == qsg_pkg::Bits8) lim = 127;
    else if (width_sel == qsg_pkg::Bits16) lim = 32767;
    else lim = 64'h7FFFFFFF;
    a = (peak_reg < lim) ? longint'(peak_reg) : lim;
    v = (a * sine_q30(turn[31:0]) + (64'sd1 <<< 29)) >>> 30;
    if (v > a) v = a;
    if (v < -a) v = -a;
    if (width_sel == qsg_pkg::Bits8) v = v + 128;
    p = p + s;
    if (p >= fs) p = p - fs;
    phase_res = p[17:0];
    phase_inc = s[17:0];
    return v[31:0];
  endfunction

  function automatic int draw_wait();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%s", msg);
    mismatch_count++;
  endtask

  // Driver: present ticks from the queue, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) expected_samples.push_back(next_sample(s_axis_tdata[0]));
      if (send_wait > 0) begin
        send_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        s_axis_tdata  <= {7'b0, tick_queue.pop_front()};
        s_axis_tvalid <= 1'b1;
        send_wait = draw_wait();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each sample transaction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d at %0t", $signed(m_axis_tdata),
                                    $realtime));
        end else begin
          logic [31:0] want;
          want = expected_samples.pop_front();
          if (want !== m_axis_tdata)
            report_mismatch($sformatf("sample mismatch at %0t: expected %0d got %0d",
                                      $realtime, $signed(want), $signed(m_axis_tdata)));
        end
        recv_wait = draw_wait();
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Wait until the block is idle
  task automatic drain();
    while (tick_queue.size() > 0 || s_axis_tvalid || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      qsg_pkg::RegSampleRate:    fs_reg    = data[17:0];
      qsg_pkg::RegSampleBits:    width_sel = data[1:0];
      qsg_pkg::RegToneFrequency: tone_reg  = data[17:0];
      default:                   peak_reg  = data[30:0];
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] rate, input logic [31:0] bits_sel,
                           input logic [31:0] tone, input logic [31:0] peak);
    drain();
    write_reg(qsg_pkg::RegSampleRate, rate);
    write_reg(qsg_pkg::RegSampleBits, bits_sel);
    write_reg(qsg_pkg::RegToneFrequency, tone);
    write_reg(qsg_pkg::RegAmplitude, peak);
  endtask

  task automatic add_ticks(input int n, input int restart_pct);
    for (int i = 0; i < n; i++) tick_queue.push_back($urandom_range(0, 99) < restart_pct);
  endtask

  initial begin
    fs_reg = 18'd8000; width_sel = 2'd1; tone_reg = 18'd440; peak_reg = 31'd1000;
    phase_res = '0; phase_inc = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ticks before any restart stay at zero, then a default tone
    tick_queue.push_back(1'b0); tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1); add_ticks(3, 0);
    // Extremes: 8-bit at full scale, 32-bit peak, odd widths and rates
    configure(4, qsg_pkg::Bits8, 1, 32'hFFFF_FFFF);
    tick_queue.push_back(1'b1); add_ticks(4, 0);
    configure(32'hFFFC_0000, 3, 32'h0003_FFFF, 32'h7FFF_FFFF);   // rate reads as zero
    tick_queue.push_back(1'b1); add_ticks(2, 0);
    configure(32'h0003_FFFF, 2, 32'h0003_FFFF, 32'h7FFF_FFFF);
    tick_queue.push_back(1'b1); add_ticks(3, 0);
    configure(1, qsg_pkg::Bits16, 0, 0);
    tick_queue.push_back(1'b1); tick_queue.push_back(1'b0);
    // Rate change mid-run, then tone change that waits for a restart
    configure(48000, 2, 12000, 32'h4000_0000);
    tick_queue.push_back(1'b1); add_ticks(2, 0);
    drain();
    write_reg(qsg_pkg::RegSampleRate, 7);
    write_reg(qsg_pkg::RegToneFrequency, 3);
    add_ticks(3, 0); tick_queue.push_back(1'b1); tick_queue.push_back(1'b0);

    // Random phases, some without any idling
    for (int ph = 0; ph < 8; ph++) begin
      logic [31:0] rate;
      rate = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(1, 1000);
      configure(rate, $urandom(), ($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000)),
                ($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 300)));
      quiet = (ph % 3 == 2);
      add_ticks(200, 8);
    end
    drain();
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
